>>> rtl/wsmfb_pkg.sv
// Package for the masked frame builder: shared types, codes and constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package wsmfb_pkg;

  // Widths of the stream fields
  localparam int unsigned LEN_W    = 63;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned OPCODE_W = 4;
  localparam int unsigned S_DATA_W = 72;  // frame_length + payload_byte, padded to bytes
  localparam int unsigned SEC_W    = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned STEP_W   = 4;   // counts header bytes, at most 14

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MASK_KEY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OPCODE   = 1'b1;

  // Reset values of the configuration registers
  localparam logic [KEY_W-1:0]    MASK_KEY_RESET = 32'h1234_5678;
  localparam logic [OPCODE_W-1:0] OPCODE_RESET   = 4'h1;

  // Header constants
  localparam logic [BYTE_W-1:0] FIN_BIT     = 8'h80;
  localparam logic [BYTE_W-1:0] MASK_BIT    = 8'h80;
  localparam logic [6:0]        LEN_CODE_16 = 7'd126;
  localparam logic [6:0]        LEN_CODE_64 = 7'd127;
  localparam logic [LEN_W-1:0]  LEN_MAX_SHORT = 63'd125;
  localparam logic [LEN_W-1:0]  LEN_LIMIT_16  = 63'd65536;

  // Header length before the key bytes, per length class
  localparam logic [STEP_W-1:0] HDR_LEN_SHORT = 4'd2;
  localparam logic [STEP_W-1:0] HDR_LEN_16    = 4'd4;
  localparam logic [STEP_W-1:0] HDR_LEN_64    = 4'd10;
  localparam logic [STEP_W-1:0] KEY_BYTES     = 4'd4;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_PAYLOAD = 1'b1
  } cmd_e;

  typedef enum logic [SEC_W-1:0] {
    SEC_HEADER  = 2'd0,
    SEC_KEY     = 2'd1,
    SEC_PAYLOAD = 2'd2
  } section_e;

  typedef enum logic [1:0] {
    LEN_SHORT = 2'd0,
    LEN_16    = 2'd1,
    LEN_64    = 2'd2
  } len_class_e;

  // One queued job: a frame start or one masked payload byte
  typedef struct packed {
    cmd_e               kind;
    len_class_e         lclass;
    logic               len_zero;
    logic [LEN_W-1:0]   len;
    logic [BYTE_W-1:0]  data;
    logic               last;
  } entry_t;

  // Key byte at a position; first byte in the top bits
  function automatic logic [BYTE_W-1:0] key_byte(logic [KEY_W-1:0] key, logic [1:0] pos);
    logic [BYTE_W-1:0] b;
    case (pos)
      2'd0:    b = key[31:24];
      2'd1:    b = key[23:16];
      2'd2:    b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/websocket_masked_frame_builder.sv
// Top level of the masked client frame builder: configuration registers,
// front end, job queue and byte emitter. Depends on wsmfb_pkg and submodules.
//
// A start command (tuser = 0) turns into the frame header: the FIN/opcode
// byte, the masked length byte with 0, 2 or 8 big-endian extended length
// bytes, then the four key bytes, i.e. 6, 8 or 14 output transfers. A payload
// command (tuser = 1) gives one masked byte; with no frame open it is taken
// and dropped. Input is taken every cycle while the job queue has room; the
// emitter puts out one byte per cycle while the receiver is ready, so payload
// streams run at one byte per cycle unless stalled. Output is registered; an
// input goes through the job queue and the output register. Configuration
// writes are always accepted and should be made while the block is idle.
`default_nettype none

module websocket_masked_frame_builder #(
  parameter int unsigned QueueDepth = wsmfb_pkg::QUEUE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: frame_length [62:0], payload_byte [70:63], zero [71]
  input  logic [wsmfb_pkg::S_DATA_W-1:0]     s_axis_tdata,
  // tuser: command
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: out_byte
  output logic [wsmfb_pkg::BYTE_W-1:0]       m_axis_tdata,
  // tuser: section
  output logic [wsmfb_pkg::SEC_W-1:0]        m_axis_tuser,
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wsmfb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wsmfb_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import wsmfb_pkg::*;

  logic [KEY_W-1:0]    mask_key_q;
  logic [OPCODE_W-1:0] opcode_q;
  logic                q_push, q_ready, q_pop, q_valid;
  entry_t              push_entry, head_entry;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_key_q <= MASK_KEY_RESET;
      opcode_q   <= OPCODE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MASK_KEY: mask_key_q <= cfg_data_i[KEY_W-1:0];
        REG_OPCODE:   opcode_q   <= cfg_data_i[OPCODE_W-1:0];
        default: ;
      endcase
    end
  end

  wsmfb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .mask_key_i    (mask_key_q),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_entry_o     (push_entry)
  );

  wsmfb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  wsmfb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (head_entry),
    .q_pop_o       (q_pop),
    .mask_key_i    (mask_key_q),
    .opcode_i      (opcode_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> rtl/wsmfb_front.sv
// Front end of the frame builder: accepts commands, tracks the open frame,
// masks payload bytes and queues jobs. Depends on wsmfb_pkg.
`default_nettype none

module wsmfb_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: frame_length [62:0], payload_byte [70:63], zero [71]
  input  logic [wsmfb_pkg::S_DATA_W-1:0]     s_axis_tdata,
  // tuser: command
  input  logic                               s_axis_tuser,
  input  logic [wsmfb_pkg::KEY_W-1:0]        mask_key_i,
  input  logic                               q_ready_i,
  output logic                               q_push_o,
  output wsmfb_pkg::entry_t                  q_entry_o
);
  import wsmfb_pkg::*;

  logic [LEN_W-1:0]  remain_q, remain_d;
  logic [1:0]        pos_q, pos_d;
  logic              accept;
  logic              open_frame;
  logic [LEN_W-1:0]  len;
  logic [BYTE_W-1:0] pbyte;
  cmd_e              cmd;

  assign s_axis_tready = q_ready_i;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign len    = s_axis_tdata[LEN_W-1:0];
  assign pbyte  = s_axis_tdata[LEN_W +: BYTE_W];
  assign cmd    = cmd_e'(s_axis_tuser);
  assign open_frame = (remain_q != '0);

  // Classify the command and build the queued job
  always_comb begin
    remain_d = remain_q;
    pos_d    = pos_q;
    q_push_o = 1'b0;
    q_entry_o.kind     = cmd;
    q_entry_o.len      = len;
    q_entry_o.len_zero = (len == '0);
    q_entry_o.data     = pbyte ^ key_byte(mask_key_i, pos_q);
    q_entry_o.last     = (remain_q == LEN_W'(1));
    if (len <= LEN_MAX_SHORT) begin
      q_entry_o.lclass = LEN_SHORT;
    end else if (len < LEN_LIMIT_16) begin
      q_entry_o.lclass = LEN_16;
    end else begin
      q_entry_o.lclass = LEN_64;
    end
    if (accept) begin
      unique case (cmd)
        CMD_START: begin
          remain_d = len;
          pos_d    = 2'd0;
          q_push_o = 1'b1;
        end
        CMD_PAYLOAD: begin
          // drop a payload byte when no frame is open
          if (open_frame) begin
            remain_d = remain_q - LEN_W'(1);
            pos_d    = pos_q + 2'd1;
            q_push_o = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Hold the frame tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
      pos_q    <= '0;
    end else begin
      remain_q <= remain_d;
      pos_q    <= pos_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/wsmfb_queue.sv
// Short job queue between the front end and the byte emitter.
// Depends on wsmfb_pkg for the job type.
`default_nettype none

module wsmfb_queue #(
  parameter int unsigned Depth = wsmfb_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wsmfb_pkg::entry_t entry_i,
  output logic              ready_o,
  input  logic              pop_i,
  output logic              valid_o,
  output wsmfb_pkg::entry_t entry_o
);
  import wsmfb_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign ready_o = (count_q != CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = slots_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Store the incoming job
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/wsmfb_back.sv
// Byte emitter of the frame builder: expands queued jobs into frame bytes
// and drives the registered output stream. Depends on wsmfb_pkg.
`default_nettype none

module wsmfb_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  input  wsmfb_pkg::entry_t                q_entry_i,
  output logic                             q_pop_o,
  input  logic [wsmfb_pkg::KEY_W-1:0]      mask_key_i,
  input  logic [wsmfb_pkg::OPCODE_W-1:0]   opcode_i,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: out_byte
  output logic [wsmfb_pkg::BYTE_W-1:0]     m_axis_tdata,
  // tuser: section
  output logic [wsmfb_pkg::SEC_W-1:0]      m_axis_tuser,
  output logic                             m_axis_tlast
);
  import wsmfb_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  section_e          out_sec_q;
  logic              out_last_q;

  logic              out_load;
  logic [STEP_W-1:0] hdr_len, step_last;
  logic [2:0]        len_idx;
  logic [1:0]        key_idx;
  logic [63:0]       len64;
  logic [BYTE_W-1:0] nxt_byte;
  section_e          nxt_sec;
  logic              nxt_last;
  logic              job_done;

  assign out_load = !out_valid_q || m_axis_tready;
  assign len64    = {1'b0, q_entry_i.len};

  // Header length for this length class
  always_comb begin
    unique case (q_entry_i.lclass)
      LEN_SHORT: hdr_len = HDR_LEN_SHORT;
      LEN_16:    hdr_len = HDR_LEN_16;
      LEN_64:    hdr_len = HDR_LEN_64;
      default:   hdr_len = HDR_LEN_64;
    endcase
  end

  assign step_last = hdr_len + KEY_BYTES - STEP_W'(1);
  assign len_idx   = 3'(hdr_len - STEP_W'(1) - step_q);
  assign key_idx   = 2'(step_q - hdr_len);

  // Select the next frame byte
  always_comb begin
    nxt_byte = q_entry_i.data;
    nxt_sec  = SEC_PAYLOAD;
    nxt_last = q_entry_i.last;
    job_done = 1'b1;
    if (q_entry_i.kind == CMD_START) begin
      job_done = (step_q == step_last);
      nxt_last = job_done && q_entry_i.len_zero;
      if (step_q < hdr_len) begin
        nxt_sec = SEC_HEADER;
        if (step_q == '0) begin
          nxt_byte = FIN_BIT | {4'h0, opcode_i};
        end else if (step_q == STEP_W'(1)) begin
          unique case (q_entry_i.lclass)
            LEN_SHORT: nxt_byte = MASK_BIT | {1'b0, q_entry_i.len[6:0]};
            LEN_16:    nxt_byte = MASK_BIT | {1'b0, LEN_CODE_16};
            default:   nxt_byte = MASK_BIT | {1'b0, LEN_CODE_64};
          endcase
        end else begin
          nxt_byte = len64[{len_idx, 3'b000} +: BYTE_W];
        end
      end else begin
        nxt_sec  = SEC_KEY;
        nxt_byte = key_byte(mask_key_i, key_idx);
      end
    end
  end

  assign q_pop_o = q_valid_i && out_load && job_done;

  // Step through header and key bytes of a start job
  always_comb begin
    step_d = step_q;
    if (q_valid_i && out_load && (q_entry_i.kind == CMD_START)) begin
      step_d = job_done ? '0 : step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (out_load) begin
        out_valid_q <= q_valid_i;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q <= nxt_byte;
      out_sec_q  <= nxt_sec;
      out_last_q <= nxt_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_sec_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

>>> rtl/wsmfb_checker.sv
// Port-level checks of the masked frame builder output stream, bound to the
// top level. Depends on wsmfb_pkg.
`default_nettype none

module wsmfb_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [wsmfb_pkg::BYTE_W-1:0]       m_axis_tdata,
  input  logic [wsmfb_pkg::SEC_W-1:0]        m_axis_tuser,
  input  logic                               m_axis_tlast
);
  import wsmfb_pkg::*;

  logic                 out_xfer;
  logic                 frame_start_q;  // next transfer opens a frame
  logic [SEC_W-1:0]     prev_sec_q;

  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // Track the section of the previous output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_start_q <= 1'b1;
      prev_sec_q    <= SEC_HEADER;
    end else if (out_xfer) begin
      frame_start_q <= m_axis_tlast;
      prev_sec_q    <= m_axis_tuser;
    end
  end

  // A stalled output transfer holds its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // A frame opens with a FIN header byte
  a_frame_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && frame_start_q |-> (m_axis_tuser == SEC_HEADER) && m_axis_tdata[7])
    else $error("frame does not open with a FIN header byte");

  // Payload never follows a header byte directly
  a_key_after_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !frame_start_q && (prev_sec_q == SEC_HEADER) |->
      (m_axis_tuser == SEC_HEADER) || (m_axis_tuser == SEC_KEY))
    else $error("payload byte follows header byte");

  // A frame never ends on a header byte
  a_no_hdr_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser != SEC_HEADER)
    else $error("frame ends on header byte");

endmodule

bind websocket_masked_frame_builder wsmfb_checker u_checker (.*);

`default_nettype wire

>>> tb/sv/wsmfb_stream_checker.sv
// Stream checker for the masked frame builder: watches the command, frame byte
// and configuration channels, predicts every frame byte and compares in order.
// Depends on wsmfb_pkg for field widths, register indexes and section codes.

module wsmfb_stream_checker
  import wsmfb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [S_DATA_W-1:0]   s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [BYTE_W-1:0]     m_axis_tdata,
  input  logic [SEC_W-1:0]      m_axis_tuser,
  input  logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    section_e          sec;
    logic              last;
  } wire_byte_t;

  wire_byte_t        wire_bytes_q[$];
  logic [KEY_W-1:0]    key_r;
  logic [OPCODE_W-1:0] opcode_r;
  logic [LEN_W-1:0]    left_r;
  logic [1:0]          lane_r;

  // Key byte for a payload lane, lane 0 in the top bits
  function automatic logic [BYTE_W-1:0] key_lane(logic [1:0] lane);
    logic [KEY_W-1:0] sh;
    sh = key_r >> ((3 - lane) * 8);
    return sh[BYTE_W-1:0];
  endfunction

  task automatic emit(logic [BYTE_W-1:0] data, section_e sec, logic last);
    wire_byte_t wb;
    wb.data = data;
    wb.sec  = sec;
    wb.last = last;
    wire_bytes_q.push_back(wb);
  endtask

  // Expand one accepted command into the frame bytes it puts on the wire
  task automatic predict_frame_bytes(cmd_e cmd, logic [LEN_W-1:0] len,
                                     logic [BYTE_W-1:0] pb);
    logic [63:0] len64;
    int k;
    len64 = {1'b0, len};
    if (cmd == CMD_START) begin
      emit(FIN_BIT | {4'b0, opcode_r}, SEC_HEADER, 1'b0);
      if (len <= LEN_MAX_SHORT) begin
        emit(MASK_BIT | len64[7:0], SEC_HEADER, 1'b0);
      end else if (len < LEN_LIMIT_16) begin
        emit(MASK_BIT | {1'b0, LEN_CODE_16}, SEC_HEADER, 1'b0);
        emit(len64[15:8], SEC_HEADER, 1'b0);
        emit(len64[7:0], SEC_HEADER, 1'b0);
      end else begin
        emit(MASK_BIT | {1'b0, LEN_CODE_64}, SEC_HEADER, 1'b0);
        for (k = 7; k >= 0; k--) emit(len64[k*8 +: 8], SEC_HEADER, 1'b0);
      end
      for (k = 0; k < 4; k++) emit(key_lane(k[1:0]), SEC_KEY, (k == 3) && (len == '0));
      left_r = len;
      lane_r = 2'd0;
    end else if (left_r != '0) begin
      // Payload byte of an open frame; with no frame open it is dropped
      left_r = left_r - 1'b1;
      emit(pb ^ key_lane(lane_r), SEC_PAYLOAD, left_r == '0);
      lane_r = lane_r + 2'd1;
    end
  endtask

  task automatic check_frame_byte();
    wire_byte_t wb;
    if (wire_bytes_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("unexpected frame byte: data %h section %0d last %0d",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end else begin
      wb = wire_bytes_q.pop_front();
      if (m_axis_tdata !== wb.data || m_axis_tuser !== wb.sec || m_axis_tlast !== wb.last) begin
        fail_count_o++;
        if (fail_count_o <= 10)
          $display("frame byte mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                   wb.data, wb.sec, wb.last, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end
    end
  endtask

  // Outputs before inputs: a command never reaches the output in its own cycle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wire_bytes_q.delete();
      key_r        = MASK_KEY_RESET;
      opcode_r     = OPCODE_RESET;
      left_r       = '0;
      lane_r       = 2'd0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_frame_byte();
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_MASK_KEY) key_r = cfg_data_i;
        else if (cfg_index_i == REG_OPCODE) opcode_r = cfg_data_i[OPCODE_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_frame_bytes(cmd_e'(s_axis_tuser), s_axis_tdata[LEN_W-1:0],
                            s_axis_tdata[LEN_W +: BYTE_W]);
      pending_o = wire_bytes_q.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the masked frame builder: clock, reset, command stimulus,
// register writes and the verdict. Depends on wsmfb_pkg and wsmfb_stream_checker.

module tb;
  import wsmfb_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS = 96;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [BYTE_W-1:0]     m_axis_tdata;
  logic [SEC_W-1:0]      m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int                    fail_count;
  int                    pending;
  int                    gap_odds;     // 0 turns idling off
  int                    quiet_cycles;
  int                    useful_items; // items that open a frame or extend one
  logic [LEN_W-1:0]      open_left;

  websocket_masked_frame_builder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  wsmfb_stream_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // End the run when no transfer of any kind happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: stall in random bursts while idling is on
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (gap_odds != 0 && $urandom_range(0, 2 * gap_odds) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
    end
  end

  // Present one command and hold it until the transfer; returns at a falling edge
  task automatic send_command(cmd_e cmd, logic [LEN_W-1:0] len, logic [BYTE_W-1:0] pb);
    if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {1'b0, pb, len};
    s_axis_tuser  = cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    if (cmd == CMD_START) begin
      open_left = len;
      useful_items++;
    end else if (open_left != '0) begin
      open_left = open_left - 1'b1;
      useful_items++;
    end
  endtask

  task automatic send_start(logic [LEN_W-1:0] len);
    send_command(CMD_START, len, BYTE_W'($urandom));
  endtask

  task automatic send_payload(logic [BYTE_W-1:0] pb);
    send_command(CMD_PAYLOAD, LEN_W'({$urandom, $urandom}), pb);
  endtask

  // Drop valid, wait for every expected byte, then let dropped commands drain
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Frames with random content; short ones mostly complete, longer ones cut short,
  // some overrun, some preceded by a stray payload byte
  task automatic send_random_frame();
    logic [LEN_W-1:0] len;
    int pick;
    int n_pay;
    int k;
    pick = $urandom_range(0, 19);
    if (pick < 12) len = LEN_W'($urandom_range(0, 12));
    else if (pick < 15) len = LEN_W'($urandom_range(120, 131));
    else if (pick < 17) len = LEN_W'($urandom_range(65530, 65541));
    else len = LEN_W'({$urandom, $urandom});
    n_pay = (len < 16) ? int'(len) : int'($urandom_range(0, 10));
    pick = $urandom_range(0, 9);
    if (pick == 0) n_pay = int'($urandom_range(0, n_pay));
    else if (pick == 1) n_pay = n_pay + int'($urandom_range(1, 2));
    if ($urandom_range(0, 9) == 0) send_payload(BYTE_W'($urandom));
    send_start(len);
    for (k = 0; k < n_pay; k++) send_payload(BYTE_W'($urandom));
  endtask

  initial begin
    int phase;
    int k;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_START;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_MASK_KEY;
    cfg_data_i    = '0;
    gap_odds      = 4;
    useful_items  = 0;
    open_left     = '0;
    quiet_cycles  = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset registers, empty frame, stray payload, every length class
    send_start('0);
    send_payload(8'h3C);
    send_start(63'd125);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_start(63'd126);
    send_payload(8'hA5);
    send_start(63'd65535);
    send_start(63'd65536);
    send_start({LEN_W{1'b1}});
    send_payload(8'hFF);
    send_start(63'd1);
    send_payload(8'h5A);
    send_payload(8'h77);
    // Mask lane wraps, and the key changes while the frame stays open
    send_start(63'd6);
    for (k = 0; k < 4; k++) send_payload(BYTE_W'($urandom));
    settle();
    write_reg(REG_MASK_KEY, 32'hC3A5_0F96);
    send_payload(8'h81);
    send_payload(8'h7E);
    settle();

    // Random phases with new register settings, extremes first
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_MASK_KEY, '0);
          write_reg(REG_OPCODE, '0);
        end
        1: begin
          write_reg(REG_MASK_KEY, '1);
          write_reg(REG_OPCODE, CFG_DATA_W'(4'hF));
        end
        default: begin
          write_reg(REG_MASK_KEY, $urandom);
          write_reg(REG_OPCODE, CFG_DATA_W'($urandom_range(0, 15)));
        end
      endcase
      gap_odds = (phase == 5) ? 0 : (phase == 2 ? 0 : $urandom_range(2, 8));
      useful_items = 0;
      while (useful_items < RANDOM_ITEMS / 6) begin
        send_random_frame();
        if (phase == 3 && useful_items > 10 && useful_items < 14) settle();
      end
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
